>>> src/aoxt_pkg.sv
`default_nettype none

package aoxt_pkg;

    localparam int unsigned IDX_WIDTH = 10;
    localparam int unsigned VAL_WIDTH = 32;
    localparam int unsigned OUT_WIDTH = 32;

    typedef struct packed {
        logic clear_wr;
        logic start;
        logic combine;
        logic load_out_alu;
        logic load_out_cur;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic clear_last;
    } sts_t;

endpackage

`default_nettype wire

>>> src/alternating_or_xor_tree_update.sv
`default_nettype none

// Reduction tree over 2**LEVELS leaf words kept in one memory of 2**(LEVELS+1) words
// (node 1 is the root). Each transaction overwrites leaf s_leaf_index (low LEVELS bits)
// with s_leaf_value and returns the new root on m_root_value. Parents of leaves combine
// by OR, the level above by XOR, alternating upward. At each level the walk reads the
// sibling and writes the parent, so a transaction occupies the block from acceptance
// through the walk, plus any stall while a previous result waits on m_ready; the next
// transaction can be accepted in the cycle after that. After reset all 2**(LEVELS+1)
// memory words are cleared one word per cycle, with s_ready low.
module alternating_or_xor_tree_update #(
    parameter int unsigned LEVELS     = 10,
    parameter int unsigned WORD_WIDTH = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [aoxt_pkg::IDX_WIDTH-1:0]    s_leaf_index,
    input  wire logic [aoxt_pkg::VAL_WIDTH-1:0]    s_leaf_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [aoxt_pkg::OUT_WIDTH-1:0]         m_root_value
);

    aoxt_pkg::cmd_t cmd;
    aoxt_pkg::sts_t sts;

    aoxt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    aoxt_dp #(
        .LEVELS     (LEVELS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_leaf_index (s_leaf_index),
        .s_leaf_value (s_leaf_value),
        .m_root_value (m_root_value)
    );

endmodule

`default_nettype wire

>>> src/aoxt_ctrl.sv
`default_nettype none

module aoxt_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    output aoxt_pkg::cmd_t    cmd,
    input  wire aoxt_pkg::sts_t sts
);

    localparam logic [1:0] ST_CLEAR   = 2'd0;
    localparam logic [1:0] ST_IDLE    = 2'd1;
    localparam logic [1:0] ST_COMBINE = 2'd2;
    localparam logic [1:0] ST_FINISH  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_COMBINE;
                end
            end
            ST_COMBINE: begin
                cmd.combine = 1'b1;
                if (sts.last) begin
                    if (out_free) begin
                        cmd.load_out_alu = 1'b1;
                        m_valid_next     = 1'b1;
                        state_next       = ST_IDLE;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load_out_cur = 1'b1;
                    m_valid_next     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clear_wr, cmd.start, cmd.combine}))
        else $error("conflicting datapath commands");

    a_accept_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_COMBINE) && !s_ready)
        else $error("transaction accepted without starting the walk");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out_alu || cmd.load_out_cur) |=> m_valid)
        else $error("result loaded but not presented");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !(cmd.load_out_alu || cmd.load_out_cur))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> src/aoxt_dp.sv
`default_nettype none

module aoxt_dp #(
    parameter int unsigned LEVELS     = 10,
    parameter int unsigned WORD_WIDTH = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire aoxt_pkg::cmd_t                    cmd,
    output aoxt_pkg::sts_t                         sts,
    input  wire logic [aoxt_pkg::IDX_WIDTH-1:0]    s_leaf_index,
    input  wire logic [aoxt_pkg::VAL_WIDTH-1:0]    s_leaf_value,
    output logic [aoxt_pkg::OUT_WIDTH-1:0]         m_root_value
);

    localparam int unsigned NODE_BITS  = LEVELS + 1;
    localparam int unsigned NODE_COUNT = 2 ** NODE_BITS;

    logic [WORD_WIDTH-1:0] mem [NODE_COUNT];

    logic [NODE_BITS-1:0]  node_reg, node_next;
    logic [NODE_BITS-1:0]  clr_addr_reg;
    logic [WORD_WIDTH-1:0] cur_reg, cur_next;
    logic                  use_xor_reg, use_xor_next;
    logic [WORD_WIDTH-1:0] rd_data_reg;
    logic [aoxt_pkg::OUT_WIDTH-1:0] root_reg;

    logic [LEVELS+aoxt_pkg::IDX_WIDTH-1:0]     idx_ext;
    logic [WORD_WIDTH+aoxt_pkg::VAL_WIDTH-1:0] val_ext;
    logic [WORD_WIDTH+aoxt_pkg::OUT_WIDTH-1:0] alu_ext, cur_ext;
    logic [LEVELS-1:0]     leaf_idx;
    logic [WORD_WIDTH-1:0] leaf_word;
    logic [NODE_BITS-1:0]  parent;
    logic [WORD_WIDTH-1:0] alu;
    logic                  wr_en;
    logic [NODE_BITS-1:0]  wr_addr, rd_addr;
    logic [WORD_WIDTH-1:0] wr_data;

    assign idx_ext   = {{LEVELS{1'b0}}, s_leaf_index};
    assign val_ext   = {{WORD_WIDTH{1'b0}}, s_leaf_value};
    assign leaf_idx  = idx_ext[LEVELS-1:0];
    assign leaf_word = val_ext[WORD_WIDTH-1:0];
    assign parent    = node_reg >> 1;
    assign alu       = use_xor_reg ? (cur_reg ^ rd_data_reg) : (cur_reg | rd_data_reg);
    assign alu_ext   = {{aoxt_pkg::OUT_WIDTH{1'b0}}, alu};
    assign cur_ext   = {{aoxt_pkg::OUT_WIDTH{1'b0}}, cur_reg};

    assign sts.last       = (parent == NODE_BITS'(1));
    assign sts.clear_last = &clr_addr_reg;
    assign m_root_value   = root_reg;

    always_comb begin
        wr_en        = 1'b0;
        wr_addr      = parent;
        wr_data      = alu;
        rd_addr      = parent ^ NODE_BITS'(1);
        node_next    = node_reg;
        cur_next     = cur_reg;
        use_xor_next = use_xor_reg;
        if (cmd.clear_wr) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end else if (cmd.start) begin
            wr_en        = 1'b1;
            wr_addr      = {1'b1, leaf_idx};
            wr_data      = leaf_word;
            rd_addr      = {1'b1, leaf_idx ^ LEVELS'(1)};
            node_next    = {1'b1, leaf_idx};
            cur_next     = leaf_word;
            use_xor_next = 1'b0;
        end else if (cmd.combine) begin
            wr_en        = 1'b1;
            node_next    = parent;
            cur_next     = alu;
            use_xor_next = !use_xor_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        node_reg    <= node_next;
        cur_reg     <= cur_next;
        use_xor_reg <= use_xor_next;
        if (cmd.load_out_alu) begin
            root_reg <= alu_ext[aoxt_pkg::OUT_WIDTH-1:0];
        end else if (cmd.load_out_cur) begin
            root_reg <= cur_ext[aoxt_pkg::OUT_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_wr) begin
            clr_addr_reg <= clr_addr_reg + NODE_BITS'(1);
        end
    end

endmodule

`default_nettype wire

>>> sim/root_checker.sv
`timescale 1ns / 1ps

module root_checker #(
    parameter int unsigned LEVELS = 10
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    input  wire logic                               s_ready,
    input  wire logic [aoxt_pkg::IDX_WIDTH-1:0]     s_leaf_index,
    input  wire logic [aoxt_pkg::VAL_WIDTH-1:0]     s_leaf_value,
    input  wire logic                               m_valid,
    input  wire logic                               m_ready,
    input  wire logic [aoxt_pkg::OUT_WIDTH-1:0]     m_root_value,
    output int unsigned                             mismatch_count,
    output int unsigned                             roots_pending
);

    localparam int unsigned LEAVES = 1 << LEVELS;

    logic [aoxt_pkg::VAL_WIDTH-1:0] tree_nodes [1:2*LEAVES-1];
    logic [aoxt_pkg::OUT_WIDTH-1:0] expected_roots [$];
    int unsigned                    errors = 0;

    assign mismatch_count = errors;
    assign roots_pending  = expected_roots.size();

    function automatic logic [aoxt_pkg::OUT_WIDTH-1:0] write_leaf_get_root(
        input logic [aoxt_pkg::IDX_WIDTH-1:0] idx,
        input logic [aoxt_pkg::VAL_WIDTH-1:0] val
    );
        int unsigned                    node;
        bit                             use_xor;
        logic [aoxt_pkg::VAL_WIDTH-1:0] left_word;
        logic [aoxt_pkg::VAL_WIDTH-1:0] right_word;
        node = LEAVES + (idx % LEAVES);
        use_xor = 1'b0;
        tree_nodes[node] = val;
        while (node > 1) begin
            left_word  = tree_nodes[node];
            right_word = tree_nodes[node ^ 1];
            node = node >> 1;
            tree_nodes[node] = use_xor ? (left_word ^ right_word) : (left_word | right_word);
            use_xor = !use_xor;
        end
        return tree_nodes[1][aoxt_pkg::OUT_WIDTH-1:0];
    endfunction

    always @(posedge aclk) begin
        logic [aoxt_pkg::OUT_WIDTH-1:0] want;
        if (!aresetn) begin
            foreach (tree_nodes[k]) tree_nodes[k] = '0;
            expected_roots.delete();
        end else begin
            if (s_valid && s_ready) begin
                expected_roots.push_back(write_leaf_get_root(s_leaf_index, s_leaf_value));
            end
            if (m_valid && m_ready) begin
                if (expected_roots.size() == 0) begin
                    $error("root_value: expected none, actual %h", m_root_value);
                    errors++;
                end else begin
                    want = expected_roots.pop_front();
                    if (want !== m_root_value) begin
                        $error("root_value: expected %h, actual %h", want, m_root_value);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic [aoxt_pkg::IDX_WIDTH-1:0]     s_leaf_index = '0;
    logic [aoxt_pkg::VAL_WIDTH-1:0]     s_leaf_value = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [aoxt_pkg::OUT_WIDTH-1:0]     m_root_value;
    int unsigned                        mismatch_count;
    int unsigned                        roots_pending;
    bit                                 quiet = 1'b0;
    int unsigned                        stall_left = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    alternating_or_xor_tree_update #(
        .LEVELS     (10),
        .WORD_WIDTH (32)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_leaf_index (s_leaf_index),
        .s_leaf_value (s_leaf_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_root_value (m_root_value)
    );

    root_checker #(
        .LEVELS (10)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_leaf_index   (s_leaf_index),
        .s_leaf_value   (s_leaf_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_root_value   (m_root_value),
        .mismatch_count (mismatch_count),
        .roots_pending  (roots_pending)
    );

    // result-side backpressure in bursts
    always @(posedge aclk) begin
        if (!aresetn || quiet) begin
            m_ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic write_leaf(
        input logic [aoxt_pkg::IDX_WIDTH-1:0] idx,
        input logic [aoxt_pkg::VAL_WIDTH-1:0] val
    );
        int unsigned gap_len;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap_len = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap_len) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_leaf_index <= idx;
        s_leaf_value <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        #2_000_000;
        $display("alternating_or_xor_tree_update: mismatch");
        $finish;
    end

    initial begin
        int unsigned                    sent;
        int unsigned                    mode;
        int unsigned                    run_len;
        logic [aoxt_pkg::IDX_WIDTH-1:0] base;
        logic [aoxt_pkg::VAL_WIDTH-1:0] word;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // siblings under OR, then under XOR, extremes of both fields
        write_leaf(10'd0,    32'hFFFF_FFFF);
        write_leaf(10'd1,    32'hFFFF_FFFF);
        write_leaf(10'd1,    32'h0000_0000);
        write_leaf(10'd2,    32'hAAAA_AAAA);
        write_leaf(10'd3,    32'h5555_5555);
        write_leaf(10'd1023, 32'hFFFF_FFFF);
        write_leaf(10'd1022, 32'h0F0F_0F0F);
        write_leaf(10'd512,  32'h8000_0000);
        write_leaf(10'd511,  32'h0000_0001);
        write_leaf(10'd0,    32'h0000_0000);
        write_leaf(10'd1023, 32'h0000_0000);
        write_leaf(10'd1023, 32'hFFFF_FFFF);
        write_leaf(10'h2AA,  32'h1234_5678);
        write_leaf(10'h155,  32'h8765_4321);
        write_leaf(10'd512,  32'h8000_0000);
        write_leaf(10'd0,    32'hFFFF_FFFF);

        sent = 0;
        while (sent < 600) begin
            if (sent >= 540) quiet = 1'b1;
            mode = $urandom_range(0, 9);
            if (mode <= 5) begin
                // clustered leaves so updates share ancestors
                base = 10'($urandom_range(0, 1023)) & 10'h3F8;
                write_leaf(base | 10'($urandom_range(0, 7)), $urandom);
                sent++;
            end else if (mode <= 7) begin
                write_leaf(10'($urandom_range(0, 1023)), $urandom);
                sent++;
            end else if (mode == 8) begin
                word = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                write_leaf(10'($urandom_range(0, 1023)), word);
                sent++;
            end else begin
                // sweep of consecutive leaves
                base = 10'($urandom_range(0, 1023));
                run_len = $urandom_range(2, 8);
                for (int unsigned k = 0; k < run_len; k++) begin
                    write_leaf(base + 10'(k), $urandom);
                    sent++;
                end
            end
        end
        s_valid <= 1'b0;

        while (roots_pending != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("alternating_or_xor_tree_update: match");
        end else begin
            $display("alternating_or_xor_tree_update: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
src/aoxt_pkg.sv
src/aoxt_ctrl.sv
src/aoxt_dp.sv
src/alternating_or_xor_tree_update.sv
sim/root_checker.sv
sim/testbench.sv
